// ===== sv/mm_pkg.sv =====
// Shared types and constants of the matrix multiply block.
`timescale 1ns / 1ps

package mm_pkg;

  // Fixed field widths
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned COORD_W   = 3;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned PROD_W    = 2 * ELEM_W;
  localparam int unsigned SUM_W     = 35;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned S_DATA_W  = 24;
  localparam int unsigned M_DATA_W  = 48;

  // Input item kinds
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_A    = 2'd0,
    FUNC_WR_B    = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_WAIT
  } state_e;

endpackage

// ===== sv/matrix_multiply.sv =====
// Top level of the matrix multiply block: element stores, MAC sequencer, output register.
`timescale 1ns / 1ps

// Usage:
//   Slave channel: each transfer writes one element of A (tuser = write A) or of B
//   (tuser = write B) at row/col, or starts a compute (tuser = compute). Writes
//   with row or col at or above MAX_DIM, and tuser code 3, are dropped.
//   Master channel: a compute sends every element of C = A x B in row-major
//   order; tlast marks the final element. Sum is signed Q19.16, 35 bits.
//   Config port: write rows_a, inner_dim, cols_b only while the block is idle;
//   0 acts as 1 and values above MAX_DIM act as MAX_DIM.
// Timing:
//   A compute walks one read of A and B per cycle for each element of C from
//   two RAMs with registered read data, through a registered multiplier and
//   accumulator, then waits for the sum and a free output register before the
//   next element. s_tready is low while a compute runs.
// Reset and stalls:
//   Reset clears the sequencer and sets each size to 8; store contents are
//   undefined until written. When the receiver stalls, the finished element
//   waits in the output register while the next one is computed, then the
//   sequencer holds until the output register frees.
module matrix_multiply #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave stream: tdata = row[2:0], col[5:3], value[21:6], zeros above
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [mm_pkg::S_DATA_W-1:0]         s_tdata_i,
  // tuser = func[1:0]
  input  logic [mm_pkg::FUNC_W-1:0]           s_tuser_i,
  // Master stream: tdata = out_row[2:0], out_col[5:3], sum[40:6], zeros above
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [mm_pkg::M_DATA_W-1:0]         m_tdata_o,
  output logic                                m_tlast_o,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [mm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mm_pkg::CFG_W-1:0]            cfg_data_i
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = mm_pkg::COORD_W;
  localparam int unsigned EW    = mm_pkg::ELEM_W;
  localparam int unsigned PW    = mm_pkg::PROD_W;
  localparam int unsigned SW    = mm_pkg::SUM_W;
  localparam int unsigned KW    = mm_pkg::CFG_W;

  // Configuration registers
  logic [KW-1:0] rows_a_q, inner_dim_q, cols_b_q;

  // Sequencer
  mm_pkg::state_e state_q, state_d;
  logic [CW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;

  // MAC pipeline
  logic                 rd_vld_q, rd_first_q, rd_last_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] prod_d;
  logic                 prod_vld_q, prod_first_q, prod_last_q;
  logic [SW-1:0]        acc_q, acc_d;
  logic                 done_q;

  // Output register
  logic          m_vld_q, m_last_q;
  logic [CW-1:0] m_row_q, m_col_q;
  logic [SW-1:0] m_sum_q;

  // Input fields
  logic [CW-1:0]  in_row, in_col;
  logic [EW-1:0]  in_value;
  mm_pkg::func_e  in_func;
  logic           s_acc, in_range, we_a, we_b, start;
  logic [AW-1:0]  waddr, raddr_a, raddr_b;
  logic [EW-1:0]  rdata_a, rdata_b;

  // Clamped sizes and loop bounds
  logic [KW-1:0] dim_m, dim_n, dim_p;
  logic [CW-1:0] last_m, last_n, last_p;
  logic          issue, out_free, load_out, k_end, j_end, i_end;

  function automatic logic [mm_pkg::CFG_W-1:0] clamp_dim(input logic [mm_pkg::CFG_W-1:0] v);
    logic [mm_pkg::CFG_W-1:0] r;
    if (v == '0) begin
      r = mm_pkg::CFG_W'(1);
    end else if (v > mm_pkg::CFG_W'(MAX_DIM)) begin
      r = mm_pkg::CFG_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign dim_m  = clamp_dim(rows_a_q);
  assign dim_n  = clamp_dim(inner_dim_q);
  assign dim_p  = clamp_dim(cols_b_q);
  assign last_m = CW'(dim_m - KW'(1));
  assign last_n = CW'(dim_n - KW'(1));
  assign last_p = CW'(dim_p - KW'(1));

  // Unpack the input transfer
  assign in_row   = s_tdata_i[CW-1:0];
  assign in_col   = s_tdata_i[2*CW-1:CW];
  assign in_value = s_tdata_i[2*CW+EW-1:2*CW];
  assign in_func  = mm_pkg::func_e'(s_tuser_i);

  assign s_tready_o = (state_q == mm_pkg::ST_IDLE);
  assign s_acc      = s_tvalid_i && s_tready_o;
  assign in_range   = ({1'b0, in_row} < (CW + 1)'(MAX_DIM)) &&
                      ({1'b0, in_col} < (CW + 1)'(MAX_DIM));

  // Decode the input transfer
  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    start = 1'b0;
    case (in_func)
      mm_pkg::FUNC_WR_A:    we_a  = s_acc && in_range;
      mm_pkg::FUNC_WR_B:    we_b  = s_acc && in_range;
      mm_pkg::FUNC_COMPUTE: start = s_acc;
      default: begin
        we_a  = 1'b0;
        we_b  = 1'b0;
        start = 1'b0;
      end
    endcase
  end

  assign waddr   = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);
  assign raddr_a = AW'(i_q) * AW'(MAX_DIM) + AW'(k_q);
  assign raddr_b = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);

  mm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign k_end    = (k_q == last_n);
  assign j_end    = (j_q == last_p);
  assign i_end    = (i_q == last_m);
  assign out_free = !m_vld_q || m_tready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mm_pkg::ST_IDLE: if (start) begin
        state_d = mm_pkg::ST_MAC;
      end
      mm_pkg::ST_MAC: if (k_end) begin
        state_d = mm_pkg::ST_WAIT;
      end
      mm_pkg::ST_WAIT: if (done_q && out_free) begin
        state_d = (i_end && j_end) ? mm_pkg::ST_IDLE : mm_pkg::ST_MAC;
      end
      default: state_d = mm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs and loop counters
  always_comb begin
    issue    = 1'b0;
    load_out = 1'b0;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    case (state_q)
      mm_pkg::ST_IDLE: if (start) begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
      end
      mm_pkg::ST_MAC: begin
        issue = 1'b1;
        k_d   = k_end ? '0 : k_q + CW'(1);
      end
      mm_pkg::ST_WAIT: if (done_q && out_free) begin
        load_out = 1'b1;
        if (j_end) begin
          j_d = '0;
          i_d = i_q + CW'(1);
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      default: begin
        issue    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // Multiply and accumulate
  assign prod_d = $signed(rdata_a) * $signed(rdata_b);
  assign acc_d  = (prod_first_q ? SW'(0) : acc_q) + {{(SW - PW){prod_q[PW-1]}}, prod_q};

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= KW'(8);
      inner_dim_q <= KW'(8);
      cols_b_q    <= KW'(8);
    end else if (cfg_we_i) begin
      case (mm_pkg::reg_idx_e'(cfg_idx_i))
        mm_pkg::REG_ROWS_A:    rows_a_q    <= cfg_data_i;
        mm_pkg::REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        mm_pkg::REG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mm_pkg::ST_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      // Hold the finished sum until the output register takes it
      if (prod_vld_q && prod_last_q) begin
        done_q <= 1'b1;
      end else if (load_out) begin
        done_q <= 1'b0;
      end
      if (load_out) begin
        m_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_first_q   <= (k_q == '0);
    rd_last_q    <= k_end;
    prod_q       <= prod_d;
    prod_first_q <= rd_first_q;
    prod_last_q  <= rd_last_q;
    if (prod_vld_q) begin
      acc_q <= acc_d;
    end
    if (load_out) begin
      m_row_q  <= i_q;
      m_col_q  <= j_q;
      m_sum_q  <= acc_q;
      m_last_q <= i_end && j_end;
    end
  end

  assign m_tvalid_o = m_vld_q;
  assign m_tlast_o  = m_last_q;
  assign m_tdata_o  = {(mm_pkg::M_DATA_W - SW - 2 * CW)'(0), m_sum_q, m_col_q, m_row_q};

`ifndef ASSERT_OFF
  // An idle sequencer has an empty MAC pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mm_pkg::ST_IDLE) |-> (!rd_vld_q && !prod_vld_q && !done_q))
    else $error("MAC pipeline busy while idle");

  // No finished sum is pending while reads for the next element issue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mm_pkg::ST_MAC) |-> !done_q)
    else $error("finished sum pending during MAC walk");

  // Loading the final element returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && i_end && j_end) |=> (state_q == mm_pkg::ST_IDLE))
    else $error("compute did not end after final element");
`endif

endmodule

// ===== sv/mm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb_matrix_multiply.sv =====
// Self-checking stream testbench for the matrix multiply block.
`timescale 1ns / 1ps

module tb_matrix_multiply;

  localparam int unsigned MAX_DIM = 8;
  // Unused tuser code and unused register index, both to be dropped by the block
  localparam logic [mm_pkg::FUNC_W-1:0]    FUNC_SPARE = 2'd3;
  localparam logic [mm_pkg::CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

  // One element load or compute request
  typedef struct packed {
    logic [mm_pkg::FUNC_W-1:0]  func;
    logic [mm_pkg::COORD_W-1:0] row;
    logic [mm_pkg::COORD_W-1:0] col;
    logic [mm_pkg::ELEM_W-1:0]  value;
  } elem_op_t;

  // One element of the product
  typedef struct packed {
    logic [mm_pkg::COORD_W-1:0] row;
    logic [mm_pkg::COORD_W-1:0] col;
    logic [mm_pkg::SUM_W-1:0]   dot;
    logic                       last;
  } prod_elem_t;

  logic                         clk_i      = 1'b0;
  logic                         rst_ni     = 1'b0;
  logic                         s_tvalid_i = 1'b0;
  logic                         s_tready_o;
  logic [mm_pkg::S_DATA_W-1:0]  s_tdata_i  = '0;
  logic [mm_pkg::FUNC_W-1:0]    s_tuser_i  = '0;
  logic                         m_tvalid_o;
  logic                         m_tready_i = 1'b0;
  logic [mm_pkg::M_DATA_W-1:0]  m_tdata_o;
  logic                         m_tlast_o;
  logic                         cfg_we_i   = 1'b0;
  logic [mm_pkg::CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [mm_pkg::CFG_W-1:0]     cfg_data_i = '0;

  matrix_multiply #(.MAX_DIM(MAX_DIM)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Pending requests, expected product elements, error count
  elem_op_t   op_q[$];
  prod_elem_t product_q[$];
  int         err_cnt = 0;

  // Mirror of the block: element stores and size registers
  logic signed [mm_pkg::ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [mm_pkg::ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  logic [mm_pkg::CFG_W-1:0] rows_reg  = 4'd8;
  logic [mm_pkg::CFG_W-1:0] inner_reg = 4'd8;
  logic [mm_pkg::CFG_W-1:0] cols_reg  = 4'd8;

  // Generator bookkeeping: entries loaded so far and sizes in force
  bit a_loaded [MAX_DIM*MAX_DIM];
  bit b_loaded [MAX_DIM*MAX_DIM];
  int gen_m = 8;
  int gen_n = 8;
  int gen_p = 8;
  int n_items = 0;

  // Idle control for both stream sides
  bit s_idle_en = 1'b0;
  bit m_idle_en = 1'b0;
  int s_gap = 0;
  int m_gap = 0;
  bit s_took = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Effective size of a register value: 0 acts as 1, above MAX_DIM acts as MAX_DIM
  function automatic int dim_of(logic [mm_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Update the mirror for one accepted request and queue the product it causes
  task automatic step_matmul(elem_op_t op);
    longint     acc;
    prod_elem_t pe;
    int         m, n, p;
    m = dim_of(rows_reg);
    n = dim_of(inner_reg);
    p = dim_of(cols_reg);
    if (op.func == mm_pkg::FUNC_WR_A) begin
      a_mem[op.row * MAX_DIM + op.col] = op.value;
    end else if (op.func == mm_pkg::FUNC_WR_B) begin
      b_mem[op.row * MAX_DIM + op.col] = op.value;
    end else if (op.func == mm_pkg::FUNC_COMPUTE) begin
      for (int i = 0; i < m; i++) begin
        for (int j = 0; j < p; j++) begin
          acc = 0;
          for (int k = 0; k < n; k++)
            acc += longint'(a_mem[i * MAX_DIM + k]) * longint'(b_mem[k * MAX_DIM + j]);
          pe.row  = i[mm_pkg::COORD_W-1:0];
          pe.col  = j[mm_pkg::COORD_W-1:0];
          pe.dot  = acc[mm_pkg::SUM_W-1:0];
          pe.last = (i == m - 1) && (j == p - 1);
          product_q.push_back(pe);
        end
      end
    end
  endtask

  task automatic report(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    err_cnt++;
  endtask

  // Sample both channels and the config port at the rising edge
  always @(posedge clk_i) begin : monitor
    prod_elem_t want;
    elem_op_t   op;
    s_took = s_tvalid_i && s_tready_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mm_pkg::REG_ROWS_A:    rows_reg  = cfg_data_i;
          mm_pkg::REG_INNER_DIM: inner_reg = cfg_data_i;
          mm_pkg::REG_COLS_B:    cols_reg  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_took) begin
        op = op_q.pop_front();
        step_matmul(op);
      end
      if (m_tvalid_o && m_tready_i) begin
        if (product_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %0h last %0b",
                   $time, m_tdata_o, m_tlast_o);
          err_cnt++;
        end else begin
          want = product_q.pop_front();
          if (m_tdata_o[2:0] != want.row) report("row", want.row, m_tdata_o[2:0]);
          if (m_tdata_o[5:3] != want.col) report("col", want.col, m_tdata_o[5:3]);
          if (m_tdata_o[40:6] != want.dot) report("sum", want.dot, m_tdata_o[40:6]);
          if (m_tlast_o != want.last) report("last", want.last, m_tlast_o);
        end
      end
    end
  end

  // Drive the slave side; hold an offered transfer until it is taken
  always @(negedge clk_i) begin : driver
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else if (s_tvalid_i && !s_took) begin
      // hold
    end else if (s_gap != 0) begin
      s_gap--;
      s_tvalid_i <= 1'b0;
    end else if (s_idle_en && $urandom_range(0, 5) == 0) begin
      s_gap = $urandom_range(0, 2);
      s_tvalid_i <= 1'b0;
    end else if (op_q.size() != 0) begin
      s_tvalid_i <= 1'b1;
      s_tdata_i  <= {2'b00, op_q[0].value, op_q[0].col, op_q[0].row};
      s_tuser_i  <= op_q[0].func;
    end else begin
      s_tvalid_i <= 1'b0;
    end
  end

  // Stall the master side in short bursts
  always @(negedge clk_i) begin : sink
    if (m_gap != 0) begin
      m_gap--;
      m_tready_i <= 1'b0;
    end else if (m_idle_en && $urandom_range(0, 5) == 0) begin
      m_gap = $urandom_range(0, 2);
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  function automatic logic [mm_pkg::ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return mm_pkg::ELEM_W'($urandom);
    endcase
  endfunction

  task automatic push_op(logic [mm_pkg::FUNC_W-1:0] func, int row, int col,
                         logic [mm_pkg::ELEM_W-1:0] value);
    elem_op_t op;
    op.func  = func;
    op.row   = row[mm_pkg::COORD_W-1:0];
    op.col   = col[mm_pkg::COORD_W-1:0];
    op.value = value;
    if (func == mm_pkg::FUNC_WR_A) a_loaded[row * MAX_DIM + col] = 1'b1;
    if (func == mm_pkg::FUNC_WR_B) b_loaded[row * MAX_DIM + col] = 1'b1;
    if (func != FUNC_SPARE) n_items++;
    op_q.push_back(op);
  endtask

  // Load every entry the product will read that is still unwritten, then compute
  task automatic push_compute();
    for (int i = 0; i < gen_m; i++)
      for (int k = 0; k < gen_n; k++)
        if (!a_loaded[i * MAX_DIM + k]) push_op(mm_pkg::FUNC_WR_A, i, k, pick_value());
    for (int k = 0; k < gen_n; k++)
      for (int j = 0; j < gen_p; j++)
        if (!b_loaded[k * MAX_DIM + j]) push_op(mm_pkg::FUNC_WR_B, k, j, pick_value());
    push_op(mm_pkg::FUNC_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7),
            mm_pkg::ELEM_W'($urandom));
  endtask

  // Wait until every request is taken and every product element has arrived
  task automatic settle();
    while (op_q.size() != 0 || product_q.size() != 0 || s_tvalid_i) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [mm_pkg::CFG_IDX_W-1:0] idx, logic [mm_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      mm_pkg::REG_ROWS_A:    gen_m = dim_of(data);
      mm_pkg::REG_INNER_DIM: gen_n = dim_of(data);
      mm_pkg::REG_COLS_B:    gen_p = dim_of(data);
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random mix of loads, computes and dropped codes, closed by a compute
  task automatic random_body(int count);
    int pick;
    for (int t = 0; t < count; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)
        push_op(mm_pkg::FUNC_WR_A, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
      else if (pick < 80)
        push_op(mm_pkg::FUNC_WR_B, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
      else if (pick < 93)
        push_compute();
      else
        push_op(FUNC_SPARE, $urandom_range(0, 7), $urandom_range(0, 7),
                mm_pkg::ELEM_W'($urandom));
    end
    push_compute();
  endtask

  task automatic random_sizes();
    cfg_write(mm_pkg::REG_ROWS_A, mm_pkg::CFG_W'($urandom_range(0, 15)));
    cfg_write(mm_pkg::REG_INNER_DIM, mm_pkg::CFG_W'($urandom_range(0, 15)));
    cfg_write(mm_pkg::REG_COLS_B, mm_pkg::CFG_W'($urandom_range(0, 15)));
    if ($urandom_range(0, 2) == 0) cfg_write(REG_SPARE, mm_pkg::CFG_W'($urandom));
    cfg_close();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Single dot product over the reset inner size, full-scale operands
    cfg_write(mm_pkg::REG_ROWS_A, 4'd1);
    cfg_write(mm_pkg::REG_COLS_B, 4'd1);
    cfg_close();
    for (int k = 0; k < MAX_DIM; k++) begin
      push_op(mm_pkg::FUNC_WR_A, 0, k, 16'h8000);
      push_op(mm_pkg::FUNC_WR_B, k, 0, 16'h8000);
    end
    push_compute();
    for (int k = 0; k < 4; k++) push_op(mm_pkg::FUNC_WR_A, 0, k, 16'h7FFF);
    push_op(mm_pkg::FUNC_WR_B, 7, 7, 16'h0001);
    push_op(FUNC_SPARE, 7, 7, 16'hFFFF);
    push_compute();
    settle();

    // Out-of-range sizes: zero inner size, oversized rows and columns
    s_idle_en = 1'b1;
    m_idle_en = 1'b1;
    cfg_write(mm_pkg::REG_ROWS_A, 4'd15);
    cfg_write(mm_pkg::REG_INNER_DIM, 4'd0);
    cfg_write(mm_pkg::REG_COLS_B, 4'd9);
    cfg_write(REG_SPARE, 4'hA);
    cfg_close();
    random_body(20);
    settle();

    // Full size
    cfg_write(mm_pkg::REG_ROWS_A, 4'd8);
    cfg_write(mm_pkg::REG_INNER_DIM, 4'd8);
    cfg_write(mm_pkg::REG_COLS_B, 4'd8);
    cfg_close();
    random_body(20);
    settle();

    // Random sizes with random idling
    while (n_items < 270) begin
      s_idle_en = ($urandom_range(0, 3) != 0);
      m_idle_en = ($urandom_range(0, 3) != 0);
      random_sizes();
      random_body(25);
      settle();
    end

    // Closing stretch at full rate
    s_idle_en = 1'b0;
    m_idle_en = 1'b0;
    random_sizes();
    random_body(20);
    settle();
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== matrix_multiply.f =====
sv/mm_pkg.sv
sv/mm_ram.sv
sv/matrix_multiply.sv
tb/tb_matrix_multiply.sv
